// ----- sv/mabc_pkg.sv -----
// Shared types and constants for the masked alpha-blend compositor.
// No dependencies; the interfaces, the top and the testbench import this package.
`default_nettype none
package mabc_pkg;

  localparam int unsigned MaskSideDef = 160;

  localparam int unsigned DimW     = 13;
  localparam int unsigned OffW     = 12;
  localparam int unsigned ResW     = 10;
  localparam int unsigned PosW     = 12;
  localparam int unsigned MaddrW   = 15;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned PixW     = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned ProdW    = PosW + ResW;
  localparam int unsigned MixW     = 2 * ByteW;
  localparam int unsigned Lanes    = PixW / ByteW;
  localparam int unsigned GridShift = 2;

  localparam logic [ByteW-1:0] FullCover = 8'd255;
  localparam logic [MixW-1:0]  RoundHalf = 16'd127;

  localparam logic [DimW-1:0] ImageWidthRst  = 13'd640;
  localparam logic [DimW-1:0] ImageHeightRst = 13'd480;
  localparam logic [ResW-1:0] ResizedRst     = 10'd640;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth,
    CfgImageHeight,
    CfgCropLeft,
    CfgCropTop,
    CfgResizedWidth,
    CfgResizedHeight
  } cfg_idx_e;

  typedef struct packed {
    logic              valid;
    logic              blend;
    logic [MaddrW-1:0] waddr;
    logic [ByteW-1:0]  wval;
    logic [PixW-1:0]   src;
    logic [PixW-1:0]   blr;
  } item_t;

endpackage
`default_nettype wire

// ----- sv/mabc_if.sv -----
// Valid/ready channel interfaces for pixel/mask items and blended results.
// Depends on mabc_pkg for field widths.
`default_nettype none
interface mabc_in_if;
  import mabc_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [MaddrW-1:0] mask_address;
  logic [ByteW-1:0]  mask_value;
  logic [PosW-1:0]   pixel_x;
  logic [PosW-1:0]   pixel_y;
  logic [PixW-1:0]   source_pixel;
  logic [PixW-1:0]   blurred_pixel;

  modport source (output valid, op, mask_address, mask_value, pixel_x, pixel_y,
                  source_pixel, blurred_pixel, input ready);
  modport sink (input valid, op, mask_address, mask_value, pixel_x, pixel_y,
                source_pixel, blurred_pixel, output ready);
endinterface

interface mabc_out_if;
  import mabc_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] out_pixel;

  modport source (output valid, out_pixel, input ready);
  modport sink (input valid, out_pixel, output ready);
endinterface
`default_nettype wire

// ----- sv/masked_alpha_blend_compositor_top.sv -----
// Masked alpha-blend compositor: maps each pixel onto a coverage grid and blends.
// Depends on mabc_pkg, mabc_if, mabc_div and mabc_ram.
//
// Accepts one item (mask write or pixel blend) every clock while not held. A blend
// passes through one product stage, 22 stages of each pipelined position
// divider (one quotient bit per stage), grid clamp, address multiply, one
// registered coverage-RAM read, blend multiply, sum, and the divide by 255 into
// the output register. Mask writes travel the same pipeline and hit the RAM in
// order with blends, so a blend always sees every earlier write. The pipeline
// holds only while a finished blend waits at its exit and the output register
// is still occupied. Configuration writes take effect at once and must be made
// only while no item is in flight.
`default_nettype none
module masked_alpha_blend_compositor_top #(
  parameter int unsigned MaskSide = mabc_pkg::MaskSideDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mabc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mabc_pkg::CfgDataW-1:0] cfg_data_i,
  mabc_in_if.sink                            in_if,
  mabc_out_if.source                         out_if
);
  import mabc_pkg::*;

  localparam int unsigned Cells = MaskSide * MaskSide;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned GW    = $clog2(MaskSide);
  localparam int unsigned SumW  = ProdW + 1;

  // configuration
  logic [DimW-1:0] img_w_q, img_h_q;
  logic [OffW-1:0] crop_l_q, crop_t_q;
  logic [ResW-1:0] res_w_q, res_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q  <= ImageWidthRst;
      img_h_q  <= ImageHeightRst;
      crop_l_q <= '0;
      crop_t_q <= '0;
      res_w_q  <= ResizedRst;
      res_h_q  <= ResizedRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgImageWidth:    img_w_q  <= cfg_data_i;
        CfgImageHeight:   img_h_q  <= cfg_data_i;
        CfgCropLeft:      crop_l_q <= cfg_data_i[OffW-1:0];
        CfgCropTop:       crop_t_q <= cfg_data_i[OffW-1:0];
        CfgResizedWidth:  res_w_q  <= cfg_data_i[ResW-1:0];
        CfgResizedHeight: res_h_q  <= cfg_data_i[ResW-1:0];
        default: ;
      endcase
    end
  end

  logic [DimW-1:0] den_x, den_y;
  assign den_x = (img_w_q == '0) ? DimW'(1) : img_w_q;
  assign den_y = (img_h_q == '0) ? DimW'(1) : img_h_q;

  // pipeline control
  logic  en;
  item_t e_q;
  logic  out_valid_q;

  assign en          = !(e_q.valid && e_q.blend && out_valid_q && !out_if.ready);
  assign in_if.ready = en;

  // product stage plus payload carried alongside the dividers
  item_t          pl_q [ProdW+1];
  logic [ProdW-1:0] px_q, py_q;
  item_t          in_item;

  assign in_item = '{valid: in_if.valid, blend: in_if.op, waddr: in_if.mask_address,
                     wval: in_if.mask_value, src: in_if.source_pixel,
                     blr: in_if.blurred_pixel};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= ProdW; k++) pl_q[k] <= '0;
    end else if (en) begin
      pl_q[0] <= in_item;
      for (int k = 1; k <= ProdW; k++) pl_q[k] <= pl_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= in_if.pixel_x * res_w_q;
      py_q <= in_if.pixel_y * res_h_q;
    end
  end

  logic [ProdW-1:0] qx, qy;

  mabc_div #(.NumW(ProdW), .DenW(DimW)) u_div_x (
    .clk_i, .en_i(en), .num_i(px_q), .den_i(den_x), .quo_o(qx)
  );
  mabc_div #(.NumW(ProdW), .DenW(DimW)) u_div_y (
    .clk_i, .en_i(en), .num_i(py_q), .den_i(den_y), .quo_o(qy)
  );

  // grid clamp
  logic [SumW-1:0] sum_x, sum_y, sh_x, sh_y;
  logic [GW-1:0]   gx_d, gy_d, gx_q, gy_q;
  item_t           a_q;

  assign sum_x = SumW'(crop_l_q) + SumW'(qx);
  assign sum_y = SumW'(crop_t_q) + SumW'(qy);
  assign sh_x  = sum_x >> GridShift;
  assign sh_y  = sum_y >> GridShift;
  assign gx_d  = (sh_x > SumW'(MaskSide - 1)) ? GW'(MaskSide - 1) : sh_x[GW-1:0];
  assign gy_d  = (sh_y > SumW'(MaskSide - 1)) ? GW'(MaskSide - 1) : sh_y[GW-1:0];

  // address
  item_t         b_q;
  logic [AW-1:0] addr_q;
  logic          wr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
    end else if (en) begin
      a_q <= pl_q[ProdW];
      b_q <= a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gx_q   <= gx_d;
      gy_q   <= gy_d;
      addr_q <= a_q.blend ? AW'(AW'(gy_q) * AW'(MaskSide) + AW'(gx_q)) : AW'(a_q.waddr);
      wr_q   <= !a_q.blend && (32'(a_q.waddr) < 32'(Cells));
    end
  end

  // coverage memory
  logic [ByteW-1:0] cov;
  item_t            c_q;

  mabc_ram #(.Width(ByteW), .Depth(Cells)) u_mask (
    .clk_i, .en_i(en), .we_i(b_q.valid && wr_q), .addr_i(addr_q),
    .wdata_i(b_q.wval), .rdata_o(cov)
  );

  // blend: products, then sums, then divide by 255
  item_t           d_q;
  logic [MixW-1:0] ms_q [Lanes];
  logic [MixW-1:0] mb_q [Lanes];
  logic [MixW-1:0] v_q  [Lanes];
  logic            d_zero_q, d_full_q, e_zero_q, e_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
      d_q <= '0;
      e_q <= '0;
    end else if (en) begin
      c_q <= b_q;
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < Lanes; k++) begin
        ms_q[k] <= c_q.src[ByteW*k +: ByteW] * (FullCover - cov);
        mb_q[k] <= c_q.blr[ByteW*k +: ByteW] * cov;
        v_q[k]  <= ms_q[k] + mb_q[k] + RoundHalf;
      end
      d_zero_q <= cov == '0;
      d_full_q <= cov == FullCover;
      e_zero_q <= d_zero_q;
      e_full_q <= d_full_q;
    end
  end

  logic [PixW-1:0] mix;

  always_comb begin
    logic [MixW+ByteW-1:0] scaled;
    logic [ByteW-1:0]      q0;
    logic [MixW-1:0]       back;
    logic [MixW-1:0]       r;
    mix = '0;
    for (int k = 0; k < Lanes; k++) begin
      // estimate with v*257/65536, then correct by one
      scaled = {v_q[k], {ByteW{1'b0}}} + (MixW+ByteW)'(v_q[k]);
      q0     = scaled[MixW+ByteW-1:MixW];
      back   = {q0, {ByteW{1'b0}}} - MixW'(q0);
      r      = v_q[k] - back;
      mix[ByteW*k +: ByteW] = (r >= MixW'(FullCover)) ? q0 + 1'b1 : q0;
    end
  end

  // output register
  logic [PixW-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && e_q.valid && e_q.blend) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && e_q.valid && e_q.blend) begin
      out_q <= e_zero_q ? e_q.src : (e_full_q ? e_q.blr : mix);
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.out_pixel = out_q;

  // a blocked blend at the exit must hold off new transfers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_q.valid && e_q.blend && out_valid_q && !out_if.ready) |-> !in_if.ready)
    else $error("input accepted while pipeline exit is blocked");

  // a new result only comes from a blend leaving the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(e_q.valid && e_q.blend))
    else $error("result produced without a blend item");

  // a held pipeline keeps its first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(pl_q[0]))
    else $error("pipeline advanced while held");

  // a memory write never comes from a blend item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_q.valid && wr_q) |-> !b_q.blend)
    else $error("coverage write issued for a blend");
endmodule
`default_nettype wire

// ----- sv/mabc_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none
module mabc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
      rdata_o <= mem[addr_i];
    end
  end
endmodule
`default_nettype wire

// ----- sv/mabc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, one item per cycle while en_i is high.
// Denominator must stay stable while items are in flight. Depends on nothing.
`default_nettype none
module mabc_div #(
  parameter int unsigned NumW = 22,
  parameter int unsigned DenW = 13
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic      [NumW-1:0] quo_o
);
  logic [DenW-1:0] rem_q [NumW];
  logic [NumW-1:0] num_q [NumW];
  logic [NumW-1:0] quo_q [NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_step
    logic [DenW-1:0] rem_s;
    logic [NumW-1:0] num_s;
    logic [NumW-1:0] quo_s;
    logic [DenW:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_s = '0;
      assign num_s = num_i;
      assign quo_s = '0;
    end else begin : g_next
      assign rem_s = rem_q[k-1];
      assign num_s = num_q[k-1];
      assign quo_s = quo_q[k-1];
    end

    assign trial = {rem_s, num_s[NumW-1]};
    assign ge    = trial >= {1'b0, den_i};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DenW'(trial - {1'b0, den_i}) : trial[DenW-1:0];
        num_q[k] <= num_s << 1;
        quo_q[k] <= {quo_s[NumW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[NumW-1];
endmodule
`default_nettype wire

// ----- verif/tb_masked_alpha_blend_compositor_top.sv -----
// Testbench for the masked alpha-blend compositor: random mask loads and pixel blends
// checked against a behavioral predictor. Depends on mabc_pkg, mabc_if and the RTL top.
`default_nettype none
module tb_masked_alpha_blend_compositor_top;
  import mabc_pkg::*;

  localparam int unsigned Side  = MaskSideDef;
  localparam int unsigned Cells = Side * Side;
  localparam int unsigned Drain = 40;
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  // Keeps the expected blend results and a copy of the grid and the registers.
  class blend_scoreboard;
    logic [ByteW-1:0]  grid[Cells];
    bit                written[Cells];
    logic [DimW-1:0]   img_w, img_h;
    logic [OffW-1:0]   crop_l, crop_t;
    logic [ResW-1:0]   rsz_w, rsz_h;
    logic [PixW-1:0]   pending_pixels[$];
    int                errors;

    function new();
      img_w = ImageWidthRst;
      img_h = ImageHeightRst;
      crop_l = '0;
      crop_t = '0;
      rsz_w = ResizedRst;
      rsz_h = ResizedRst;
      errors = 0;
      foreach (written[i]) written[i] = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        CfgImageWidth:    img_w = val[DimW-1:0];
        CfgImageHeight:   img_h = val[DimW-1:0];
        CfgCropLeft:      crop_l = val[OffW-1:0];
        CfgCropTop:       crop_t = val[OffW-1:0];
        CfgResizedWidth:  rsz_w = val[ResW-1:0];
        CfgResizedHeight: rsz_h = val[ResW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned grid_pos(int unsigned pos, int unsigned off, int unsigned rsz,
                                   int unsigned dim);
      int unsigned d;
      int unsigned g;
      d = (dim == 0) ? 1 : dim;
      g = (off + pos * rsz / d) / 4;
      return (g > Side - 1) ? Side - 1 : g;
    endfunction

    function int unsigned cell_of(logic [PosW-1:0] x, logic [PosW-1:0] y);
      return grid_pos(y, crop_t, rsz_h, img_h) * Side + grid_pos(x, crop_l, rsz_w, img_w);
    endfunction

    function logic [PixW-1:0] blend_pixel(logic [PixW-1:0] s, logic [PixW-1:0] b,
                                          int unsigned c);
      logic [PixW-1:0] r;
      int unsigned v;
      if (c == 0) return s;
      if (c == 255) return b;
      for (int k = 0; k < Lanes; k++) begin
        v = (s[8*k +: 8] * (255 - c) + b[8*k +: 8] * c + 127) / 255;
        r[8*k +: 8] = v[7:0];
      end
      return r;
    endfunction

    function void note_item(logic op, logic [MaddrW-1:0] addr, logic [ByteW-1:0] val,
                            logic [PosW-1:0] x, logic [PosW-1:0] y,
                            logic [PixW-1:0] s, logic [PixW-1:0] b);
      if (!op) begin
        if (addr < Cells) begin
          grid[addr] = val;
          written[addr] = 1;
        end
      end else begin
        pending_pixels.push_back(blend_pixel(s, b, grid[cell_of(x, y)]));
      end
    endfunction

    function void check_pixel(logic [PixW-1:0] got);
      logic [PixW-1:0] want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (got !== want) begin
        $display("%0t: out_pixel mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int unsigned sent = 0;

  mabc_in_if  in_if ();
  mabc_out_if out_if ();

  masked_alpha_blend_compositor_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_if, .out_if
  );

  blend_scoreboard sb = new();

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  initial begin
    in_if.valid = 0;
    in_if.op = 0;
    in_if.mask_address = '0;
    in_if.mask_value = '0;
    in_if.pixel_x = '0;
    in_if.pixel_y = '0;
    in_if.source_pixel = '0;
    in_if.blurred_pixel = '0;
    out_if.ready = 0;
  end

  // Check results; the receiver may stall for a random hold after each transfer.
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (hold != 0) begin
        out_if.ready <= 0;
        repeat (hold) @(posedge clk_i);
      end
      out_if.ready <= 1;
      do @(posedge clk_i); while (!out_if.valid);
      sb.check_pixel(out_if.out_pixel);
    end
  end

  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CfgDataW-1:0];
    @(posedge clk_i);
    sb.set_reg(idx, val[CfgDataW-1:0]);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic send_item(logic op, int unsigned addr, int unsigned val, int unsigned x,
                           int unsigned y, logic [PixW-1:0] s, logic [PixW-1:0] b,
                           bit no_gap = 0);
    int unsigned gap;
    gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_if.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1;
    in_if.op <= op;
    in_if.mask_address <= addr[MaddrW-1:0];
    in_if.mask_value <= val[ByteW-1:0];
    in_if.pixel_x <= x[PosW-1:0];
    in_if.pixel_y <= y[PosW-1:0];
    in_if.source_pixel <= s;
    in_if.blurred_pixel <= b;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(op, addr[MaddrW-1:0], val[ByteW-1:0], x[PosW-1:0], y[PosW-1:0], s, b);
    sent++;
  endtask

  // Blend at a grid cell, loading the mapped cell first if it was not yet written.
  task automatic send_blend(int unsigned x, int unsigned y, bit no_gap = 0);
    if (!sb.written[sb.cell_of(x, y)])
      send_item(0, sb.cell_of(x, y), $urandom_range(0, 255), 0, 0, '0, '0, no_gap);
    send_item(1, $urandom, $urandom, x, y, $urandom, $urandom, no_gap);
  endtask

  task automatic drain();
    in_if.valid <= 0;
    @(posedge clk_i);
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic random_config(int unsigned mode);
    case (mode)
      0: begin
        write_reg(CfgImageWidth, 1); write_reg(CfgImageHeight, 1);
        write_reg(CfgCropLeft, 0); write_reg(CfgCropTop, 0);
        write_reg(CfgResizedWidth, 1); write_reg(CfgResizedHeight, 1);
      end
      1: begin
        write_reg(CfgImageWidth, 4096); write_reg(CfgImageHeight, 4096);
        write_reg(CfgCropLeft, 4095); write_reg(CfgCropTop, 4095);
        write_reg(CfgResizedWidth, 640); write_reg(CfgResizedHeight, 640);
      end
      2: begin
        // Zero sizes and out-of-range values are written as they are; a zero image size divides as one.
        write_reg(CfgImageWidth, 0); write_reg(CfgImageHeight, 8191);
        write_reg(CfgCropLeft, $urandom_range(0, 4095));
        write_reg(CfgCropTop, $urandom_range(0, 200));
        write_reg(CfgResizedWidth, 1023); write_reg(CfgResizedHeight, 0);
      end
      default: begin
        write_reg(CfgImageWidth, $urandom_range(1, 4096));
        write_reg(CfgImageHeight, $urandom_range(1, 4096));
        write_reg(CfgCropLeft, $urandom_range(0, 80));
        write_reg(CfgCropTop, $urandom_range(0, 80));
        write_reg(CfgResizedWidth, $urandom_range(1, 640));
        write_reg(CfgResizedHeight, $urandom_range(1, 640));
      end
    endcase
  endtask

  initial begin
    int unsigned n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: corner cells, coverage 0, 255 and mid, addresses past the grid,
    // pixels beyond the frame, extreme pixel values.
    send_item(0, 0, 0, 0, 0, '0, '0);
    send_item(0, Cells - 1, 255, 0, 0, '0, '0);
    send_item(0, Cells, 77, 0, 0, '0, '0);
    send_item(0, 32767, 1, 0, 0, '0, '0);
    send_item(1, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h0, 1);
    send_item(1, 0, 0, 4095, 4095, 32'h0, 32'hFFFF_FFFF, 1);
    send_item(0, 0, 128, 0, 0, '0, '0);
    send_item(1, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h0);
    send_item(0, 0, 1, 0, 0, '0, '0);
    send_item(1, 0, 0, 0, 0, 32'h00FF_00FF, 32'hFF00_FF00);
    send_item(0, 0, 254, 0, 0, '0, '0);
    send_item(1, 0, 0, 0, 0, 32'h1234_5678, 32'hFFFF_FFFF);
    drain();
    write_reg(cfg_idx_e'(CfgUnused), 1000); // no register there
    for (int m = 0; m < 3; m++) begin
      random_config(m);
      send_blend(0, 0);
      send_blend(4095, 4095);
      send_blend($urandom_range(0, 4095), $urandom_range(0, 4095));
      drain();
    end

    // Random phases: mostly blends near the frame, with mask loads mixed in.
    for (int p = 0; p < 12; p++) begin
      random_config(p < 2 ? p : 3 + p);
      n = sent;
      while (sent - n < 160) begin
        case ($urandom_range(0, 9))
          0, 1: send_item(0, $urandom_range(0, Cells - 1), $urandom, 0, 0, '0, '0);
          2: send_item(0, $urandom_range(Cells, 32767), $urandom, $urandom, $urandom,
                       $urandom, $urandom);
          3: send_blend($urandom_range(0, 4095), $urandom_range(0, 4095));
          default: send_blend($urandom_range(0, sb.img_w), $urandom_range(0, sb.img_h),
                              p[0]);
        endcase
      end
      drain();
    end

    if (sb.errors == 0)
      $display("tb_masked_alpha_blend_compositor_top: done, clean");
    else
      $display("tb_masked_alpha_blend_compositor_top: done, errors");
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_masked_alpha_blend_compositor_top: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
